/* src/rrps_pkg.sv */
`timescale 1ns / 1ps

package rrps_pkg;

	// Field and register widths
	localparam int COORD_W = 10;
	localparam int SIZE_W  = 11;
	localparam int RADIUS_W = 16;
	localparam int RAD_W   = 10;   // clamped radius never exceeds MAX_SIZE / 2
	localparam int COLOR_W = 16;
	localparam int DIST_W  = 20;   // holds 2 * (MAX_SIZE / 2)^2
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	// Largest box side; wider settings are taken as this
	localparam int MAX_SIZE = 1024;

	// Register reset values
	localparam logic [SIZE_W-1:0]   WIDTH_RST       = '0;
	localparam logic [SIZE_W-1:0]   HEIGHT_RST      = '0;
	localparam logic [RADIUS_W-1:0] RADIUS_RST      = 16'd8;
	localparam logic [COLOR_W-1:0]  BORDER_RST      = 16'hF800;
	localparam logic [COLOR_W-1:0]  FILL_RST        = 16'h0000;
	localparam logic                FILL_ENABLE_RST = 1'b1;

	typedef enum logic [2:0] {
		REG_BOX_WIDTH     = 3'd0,
		REG_BOX_HEIGHT    = 3'd1,
		REG_CORNER_RADIUS = 3'd2,
		REG_RIM_COLOR     = 3'd3,
		REG_BODY_COLOR    = 3'd4,
		REG_FILL_ENABLE   = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_BORDER = 2'd1,
		KIND_FILL   = 2'd2
	} kind_t;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
	} pixel_in_t;

	typedef struct packed {
		logic               write_pixel;
		logic [1:0]         pixel_kind;
		logic [COLOR_W-1:0] pixel_color;
	} pixel_out_t;

	// Shape values derived from the registers, ready for the per-pixel test
	typedef struct packed {
		logic [SIZE_W-1:0]  width;
		logic [SIZE_W-1:0]  height;
		logic [SIZE_W-1:0]  width_mr;    // width - radius
		logic [SIZE_W-1:0]  height_mr;   // height - radius
		logic [RAD_W-1:0]   radius;
		logic [DIST_W-1:0]  rad_sq;
		logic [DIST_W-1:0]  rad_m1_sq;
		logic [COLOR_W-1:0] rim_color;
		logic [COLOR_W-1:0] body_color;
		logic               fill_enable;
	} shape_cfg_t;

endpackage

/* src/rrps_cfg.sv */
`timescale 1ns / 1ps

module rrps_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rrps_pkg::ADDR_W-1:0]   paddr,
	input  logic [rrps_pkg::DATA_W-1:0]   pwdata,
	output logic [rrps_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output rrps_pkg::shape_cfg_t          shape
);
	import rrps_pkg::*;

	logic [SIZE_W-1:0]   box_width_q;
	logic [SIZE_W-1:0]   box_height_q;
	logic [RADIUS_W-1:0] corner_radius_q;
	logic [COLOR_W-1:0]  rim_color_q;
	logic [COLOR_W-1:0]  body_color_q;
	logic                fill_enable_q;

	logic [2:0]          reg_idx;
	logic                wr_en;

	logic [SIZE_W-1:0]   w_clamp;
	logic [SIZE_W-1:0]   h_clamp;
	logic [SIZE_W-1:0]   side_min;
	logic [RAD_W-1:0]    half_side;
	logic [RAD_W-1:0]    radius;
	logic [DIST_W-1:0]   rad_sq;
	shape_cfg_t          shape_next;
	shape_cfg_t          shape_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_width_q     <= WIDTH_RST;
			box_height_q    <= HEIGHT_RST;
			corner_radius_q <= RADIUS_RST;
			rim_color_q     <= BORDER_RST;
			body_color_q    <= FILL_RST;
			fill_enable_q   <= FILL_ENABLE_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_BOX_WIDTH:     box_width_q     <= pwdata[SIZE_W-1:0];
				REG_BOX_HEIGHT:    box_height_q    <= pwdata[SIZE_W-1:0];
				REG_CORNER_RADIUS: corner_radius_q <= pwdata[RADIUS_W-1:0];
				REG_RIM_COLOR:     rim_color_q     <= pwdata[COLOR_W-1:0];
				REG_BODY_COLOR:    body_color_q    <= pwdata[COLOR_W-1:0];
				REG_FILL_ENABLE:   fill_enable_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_BOX_WIDTH:     prdata = {{(DATA_W-SIZE_W){1'b0}}, box_width_q};
			REG_BOX_HEIGHT:    prdata = {{(DATA_W-SIZE_W){1'b0}}, box_height_q};
			REG_CORNER_RADIUS: prdata = {{(DATA_W-RADIUS_W){1'b0}}, corner_radius_q};
			REG_RIM_COLOR:     prdata = {{(DATA_W-COLOR_W){1'b0}}, rim_color_q};
			REG_BODY_COLOR:    prdata = {{(DATA_W-COLOR_W){1'b0}}, body_color_q};
			REG_FILL_ENABLE:   prdata = {{(DATA_W-1){1'b0}}, fill_enable_q};
			default:           prdata = '0;
		endcase
	end

	// Clamp the box, then the radius to half the smaller side
	assign w_clamp   = (box_width_q > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : box_width_q;
	assign h_clamp   = (box_height_q > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : box_height_q;
	assign side_min  = (w_clamp < h_clamp) ? w_clamp : h_clamp;
	assign half_side = side_min[SIZE_W-1:1];
	assign radius    = (corner_radius_q > {{(RADIUS_W-RAD_W){1'b0}}, half_side}) ?
		half_side : corner_radius_q[RAD_W-1:0];
	assign rad_sq    = {{(DIST_W-RAD_W){1'b0}}, radius} * {{(DIST_W-RAD_W){1'b0}}, radius};

	always_comb begin
		shape_next.width        = w_clamp;
		shape_next.height       = h_clamp;
		shape_next.width_mr     = w_clamp - {1'b0, radius};
		shape_next.height_mr    = h_clamp - {1'b0, radius};
		shape_next.radius       = radius;
		shape_next.rad_sq       = rad_sq;
		// (r-1)^2 = r^2 - 2r + 1
		shape_next.rad_m1_sq    = rad_sq - {{(DIST_W-RAD_W-1){1'b0}}, radius, 1'b0} + DIST_W'(1);
		shape_next.rim_color    = rim_color_q;
		shape_next.body_color   = body_color_q;
		shape_next.fill_enable  = fill_enable_q;
	end

	always_ff @(posedge clk) begin
		shape_q <= shape_next;
	end

	assign shape = shape_q;

endmodule

/* src/rrps_classify.sv */
`timescale 1ns / 1ps

module rrps_classify (
	input  rrps_pkg::pixel_in_t  pix,
	input  rrps_pkg::shape_cfg_t shape,
	output rrps_pkg::pixel_out_t shade
);
	import rrps_pkg::*;

	logic [SIZE_W-1:0] x_w;
	logic [SIZE_W-1:0] y_w;
	logic [SIZE_W-1:0] r_w;
	logic              in_box;
	logic              on_frame;
	logic [RAD_W-1:0]  dx;
	logic [RAD_W-1:0]  dy;
	logic [DIST_W-1:0] dx_sq;
	logic [DIST_W-1:0] dy_sq;
	logic [DIST_W-1:0] dist_sq;
	kind_t             kind;
	kind_t             kind_out;

	assign x_w = {1'b0, pix.pixel_x};
	assign y_w = {1'b0, pix.pixel_y};
	assign r_w = {1'b0, shape.radius};

	assign in_box = (shape.width != '0) && (shape.height != '0) &&
		(x_w < shape.width) && (y_w < shape.height);

	assign on_frame = (x_w == '0) || (x_w == shape.width - SIZE_W'(1)) ||
		(y_w == '0) || (y_w == shape.height - SIZE_W'(1));

	// Distance from the corner center along each axis, zero off the corner bands
	always_comb begin
		if (x_w < r_w) begin
			dx = RAD_W'(r_w - x_w);
		end else if (x_w >= shape.width_mr) begin
			dx = RAD_W'(x_w + SIZE_W'(1) - shape.width_mr);
		end else begin
			dx = '0;
		end
		if (y_w < r_w) begin
			dy = RAD_W'(r_w - y_w);
		end else if (y_w >= shape.height_mr) begin
			dy = RAD_W'(y_w + SIZE_W'(1) - shape.height_mr);
		end else begin
			dy = '0;
		end
	end

	assign dx_sq   = {{(DIST_W-RAD_W){1'b0}}, dx} * {{(DIST_W-RAD_W){1'b0}}, dx};
	assign dy_sq   = {{(DIST_W-RAD_W){1'b0}}, dy} * {{(DIST_W-RAD_W){1'b0}}, dy};
	assign dist_sq = dx_sq + dy_sq;

	always_comb begin
		if (!in_box) begin
			kind = KIND_NONE;
		end else if (shape.radius == '0) begin
			kind = on_frame ? KIND_BORDER : KIND_FILL;
		end else if ((dx != '0) && (dy != '0)) begin
			if (dist_sq > shape.rad_sq) begin
				kind = KIND_NONE;
			end else if (dist_sq > shape.rad_m1_sq) begin
				kind = KIND_BORDER;
			end else begin
				kind = KIND_FILL;
			end
		end else if ((dx == shape.radius) || (dy == shape.radius)) begin
			kind = KIND_BORDER;
		end else begin
			kind = KIND_FILL;
		end
	end

	always_comb begin
		kind_out = kind;
		if ((kind == KIND_FILL) && !shape.fill_enable) begin
			kind_out = KIND_NONE;
		end
		shade.write_pixel = (kind_out != KIND_NONE);
		shade.pixel_kind  = kind_out;
		case (kind_out)
			KIND_BORDER: shade.pixel_color = shape.rim_color;
			KIND_FILL:   shade.pixel_color = shape.body_color;
			default:     shade.pixel_color = '0;
		endcase
	end

endmodule

/* src/rounded_rect_pixel_shader_core.sv */
`timescale 1ns / 1ps
// Rounded-rectangle pixel shader core.
// A pixel item passes the input stage register, then the result stage register.
// Throughput: one item per cycle unless the output stalls, set by the two-register path.
// Reset (arst_n low): both stages empty, registers at their documented defaults;
// derived shape values are held in a register that follows the register file.

module rounded_rect_pixel_shader_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rrps_pkg::ADDR_W-1:0] paddr,
	input  logic [rrps_pkg::DATA_W-1:0] pwdata,
	output logic [rrps_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	// Pixel items in
	input  logic                        pixel_valid,
	output logic                        pixel_ready,
	input  rrps_pkg::pixel_in_t         pixel,
	// Shaded items out
	output logic                        shade_valid,
	input  logic                        shade_ready,
	output rrps_pkg::pixel_out_t        shade
);
	import rrps_pkg::*;

	shape_cfg_t shape;

	logic       valid_s1;
	pixel_in_t  pixel_s1;
	logic       valid_s2;
	pixel_out_t shade_s2;
	pixel_out_t shade_comb;
	logic       advance;

	// Register file plus the per-shape precompute (clamped sizes, radius, radius squares)
	rrps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.shape   (shape)
	);

	// The result stage moves whenever it is empty or its item is being taken.
	// The input stage accepts when empty or when it hands its item on this cycle,
	// so it stalls only while it is full and the result stage holds a waiting item.
	assign advance     = !valid_s2 || shade_ready;
	assign pixel_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (pixel_ready) begin
				valid_s1 <= pixel_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Capture the coordinate; hold it while the result stage is stalled
	always_ff @(posedge clk) begin
		if (pixel_valid && pixel_ready) begin
			pixel_s1 <= pixel;
		end
	end

	// Classify: corner distance squares, compare against r^2 and (r-1)^2, pick color
	rrps_classify u_classify (
		.pix   (pixel_s1),
		.shape (shape),
		.shade (shade_comb)
	);

	// Load the result register only with a live item
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			shade_s2 <= shade_comb;
		end
	end

	assign shade_valid = valid_s2;
	assign shade       = shade_s2;

`ifndef SYNTHESIS
	// A skipped pixel always carries a zero color
	assert property (@(posedge clk) disable iff (!arst_n)
		(shade_valid && !shade.write_pixel) |-> (shade.pixel_color == '0))
		else $error("untouched pixel with nonzero color");

	// Write flag and kind must agree
	assert property (@(posedge clk) disable iff (!arst_n)
		shade_valid |-> (shade.write_pixel == (shade.pixel_kind != KIND_NONE)))
		else $error("write flag disagrees with pixel kind");

	// An item held in stage one while the output stalls must not be lost
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(pixel_s1)))
		else $error("stage one item dropped during stall");

	// Accepting into a full stage one requires that its item moves on
	assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && pixel_ready && valid_s1) |-> advance)
		else $error("stage one overwritten");
`endif

endmodule
